// ----- rtl/core/ahbpe_pkg.sv -----
// Shared types, widths and character codes for the half-block pixel encoder.
// No dependencies; every module of the encoder imports this package.
`default_nettype none

package ahbpe_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W  = 11;     // register width of frame_width / frame_height
    localparam int COL_W  = 10;     // column within a text row
    localparam int ROW_W  = 9;      // row pair within a frame

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // One classified pair, handed from the front to the back
    typedef struct packed {
        logic home;
        logic fg_emit;
        logic bg_emit;
        logic row_end;
        logic frame_done;
        t_rgb top;
        t_rgb bottom;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOME,
        S_PRE,
        S_NUM,
        S_GLYPH,
        S_RESET
    } t_seq_state;

    // Byte positions that close each segment, and the index of the blue component
    localparam logic [2:0] HOME_LAST  = 3'd2;
    localparam logic [2:0] PRE_LAST   = 3'd6;
    localparam logic [2:0] SEP_POS    = 3'd3;
    localparam logic [2:0] GLYPH_LAST = 3'd2;
    localparam logic [2:0] RESET_LAST = 3'd4;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    localparam logic [7:0] CH_ESC     = 8'h1b;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_M       = 8'h6d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_THREE   = 8'h33;
    localparam logic [7:0] CH_FOUR    = 8'h34;
    localparam logic [7:0] CH_EIGHT   = 8'h38;
    localparam logic [7:0] CH_NL      = 8'h0a;
    localparam logic [7:0] GLYPH_B0   = 8'he2;
    localparam logic [7:0] GLYPH_B1   = 8'h96;
    localparam logic [7:0] GLYPH_B2   = 8'h80;

endpackage

`default_nettype wire

// ----- rtl/core/ansi_half_block_pixel_encoder_unit.sv -----
// Top level of the half-block pixel encoder: configuration registers and the
// front end, command queue and back end. Depends on ahbpe_pkg and all ahbpe_ modules.
//
// Use: each input item on the s_axis channel is one vertical pixel pair (top and
// bottom RGB) in raster order. The m_axis channel carries the terminal text, one
// byte per item: cursor home before a frame, foreground and background truecolor
// escapes when a colour changes or a row starts, the upper-half-block glyph, and
// a colour reset plus newline at each row end. tlast marks the final byte of one
// pair, tuser the final byte of a frame.
// Throughput: one output byte per cycle while the receiver takes bytes and a command
// is queued; a pair is 3 to 49 bytes, walked by the byte sequencer in the back end.
// A 4-entry command queue lets the input side run ahead by up to four pairs.
// Reset (synchronous, active low) empties the queue, restarts at the top of a
// frame, forgets both colours and sets width 80, height 48. When the receiver
// stalls, the output byte holds and input is taken until the queue fills.
// Registers: frame_width at byte address 0, frame_height at 4; write when idle.
`default_nettype none

module ansi_half_block_pixel_encoder_unit import ahbpe_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_byte
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast,
    // frame_end
    output logic             m_axis_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic             cfg_write;

    t_rgb in_top, in_bottom;
    t_cmd push_cmd, head_cmd;
    logic push, pop, full, head_valid;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = paddr[2] ? {{(32-DIM_W){1'b0}}, r_frame_height}
                                : {{(32-DIM_W){1'b0}}, r_frame_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(80);
            r_frame_height <= DIM_W'(48);
        end else if (cfg_write) begin
            if (paddr[2]) begin
                r_frame_height <= pwdata[DIM_W-1:0];
            end else begin
                r_frame_width <= pwdata[DIM_W-1:0];
            end
        end
    end

    always_comb begin
        in_top.red      = s_axis_tdata[7:0];
        in_top.green    = s_axis_tdata[15:8];
        in_top.blue     = s_axis_tdata[23:16];
        in_bottom.red   = s_axis_tdata[31:24];
        in_bottom.green = s_axis_tdata[39:32];
        in_bottom.blue  = s_axis_tdata[47:40];
    end

    ahbpe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_top          (in_top),
        .i_bottom       (in_bottom),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    ahbpe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .o_data  (head_cmd),
        .i_pop   (pop)
    );

    ahbpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast),
        .o_tuser     (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ahbpe_front.sv -----
// Front end: takes pixel pairs, tracks position and remembered colours, and
// issues one classified command per pair. Depends on ahbpe_pkg.
`default_nettype none

module ahbpe_front import ahbpe_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_rgb             i_top,
    input  wire t_rgb             i_bottom,
    input  wire logic [DIM_W-1:0] i_frame_width,
    input  wire logic [DIM_W-1:0] i_frame_height,
    input  wire logic             i_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [COL_W-1:0] r_col,  n_col;
    logic [ROW_W-1:0] r_row,  n_row;
    t_rgb             r_last_fg, r_last_bg;
    logic             r_fg_known, n_fg_known;
    logic             r_bg_known, n_bg_known;

    logic [DIM_W-1:0] w, h, pairs;
    logic [DIM_W:0]   h_inc;
    logic             last_row, row_end, accept;
    t_rgb             bottom;

    always_comb begin
        if (i_frame_width == '0) begin
            w = DIM_W'(1);
        end else if (i_frame_width > DIM_W'(MAX_WIDTH)) begin
            w = DIM_W'(MAX_WIDTH);
        end else begin
            w = i_frame_width;
        end
        if (i_frame_height == '0) begin
            h = DIM_W'(1);
        end else if (i_frame_height > DIM_W'(MAX_HEIGHT)) begin
            h = DIM_W'(MAX_HEIGHT);
        end else begin
            h = i_frame_height;
        end
    end

    assign h_inc    = {1'b0, h} + (DIM_W+1)'(1);
    assign pairs    = h_inc[DIM_W:1];
    assign last_row = ({{(DIM_W-ROW_W){1'b0}}, r_row} + DIM_W'(1)) >= pairs;
    assign row_end  = ({{(DIM_W-COL_W){1'b0}}, r_col} + DIM_W'(1)) >= w;

    // odd height: the padded bottom row is black
    assign bottom = (last_row && h[0]) ? '0 : i_bottom;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    always_comb begin
        o_cmd.home       = (r_col == '0) && (r_row == '0);
        o_cmd.fg_emit    = !r_fg_known || (r_last_fg != i_top);
        o_cmd.bg_emit    = !r_bg_known || (r_last_bg != bottom);
        o_cmd.row_end    = row_end;
        o_cmd.frame_done = row_end && last_row;
        o_cmd.top        = i_top;
        o_cmd.bottom     = bottom;
    end

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_fg_known = r_fg_known;
        n_bg_known = r_bg_known;
        if (accept) begin
            if (row_end) begin
                n_col      = '0;
                n_row      = last_row ? '0 : r_row + ROW_W'(1);
                n_fg_known = 1'b0;
                n_bg_known = 1'b0;
            end else begin
                n_col      = r_col + COL_W'(1);
                n_fg_known = 1'b1;
                n_bg_known = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_fg_known <= 1'b0;
            r_bg_known <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_fg_known <= n_fg_known;
            r_bg_known <= n_bg_known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last_fg <= i_top;
            r_last_bg <= bottom;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ahbpe_fifo.sv -----
// Short command queue between the front and the back end.
// Depends on ahbpe_pkg for the command type and depth.
`default_nettype none

module ahbpe_fifo import ahbpe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_data,
    input  wire logic i_pop
);

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;

    assign o_full  = r_count == (FIFO_PTR_W+1)'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (FIFO_PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/ahbpe_back.sv -----
// Back end: walks each command segment by segment and emits one text byte per
// cycle through an output register unless stalled. Depends on ahbpe_pkg.
`default_nettype none

module ahbpe_back import ahbpe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_pop,
    output logic      o_tvalid,
    input  wire logic i_tready,
    output logic [7:0] o_tdata,
    output logic      o_tlast,
    output logic      o_tuser
);

    t_seq_state r_state, n_state;
    t_cmd       r_cmd,   n_cmd;
    logic       r_bg,    n_bg;
    logic [2:0] r_idx,   n_idx;
    logic [1:0] r_comp,  n_comp;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_frame;

    logic       adv, cur_last, cur_frame;
    logic [7:0] cur_byte;
    t_rgb       colour;
    logic [7:0] comp_val, next_comp_val;

    // first digit position: skip leading zeros
    function automatic logic [2:0] dec_start(input logic [7:0] v);
        if (v >= 8'd100) begin
            return 3'd0;
        end else if (v >= 8'd10) begin
            return 3'd1;
        end
        return 3'd2;
    endfunction

    function automatic logic [7:0] dec_char(input logic [7:0] v, input logic [1:0] pos);
        logic [1:0]  hund;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [3:0]  ones;
        logic [7:0]  ch;
        if (v >= 8'd200) begin
            hund = 2'd2;
            rem  = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            hund = 2'd1;
            rem  = 7'(v - 8'd100);
        end else begin
            hund = 2'd0;
            rem  = v[6:0];
        end
        // rem / 10 as a multiply by 205 / 2048, exact below 100
        prod     = {8'd0, rem} * 15'd205;
        tens     = prod[14:11];
        tens_x10 = 7'({3'd0, tens} * 7'd10);
        ones     = 4'(rem - tens_x10);
        case (pos)
            2'd0:    ch = CH_ZERO + {6'd0, hund};
            2'd1:    ch = CH_ZERO + {4'd0, tens};
            default: ch = CH_ZERO + {4'd0, ones};
        endcase
        return ch;
    endfunction

    function automatic t_seq_state body_state(input t_cmd c);
        return (c.fg_emit || c.bg_emit) ? S_PRE : S_GLYPH;
    endfunction

    assign adv    = !r_out_valid || i_tready;
    assign colour = r_bg ? r_cmd.bottom : r_cmd.top;

    always_comb begin
        case (r_comp)
            2'd0:    comp_val = colour.red;
            2'd1:    comp_val = colour.green;
            default: comp_val = colour.blue;
        endcase
        next_comp_val = (r_comp == 2'd0) ? colour.green : colour.blue;
    end

    assign cur_last  = ((r_state == S_GLYPH) && (r_idx == GLYPH_LAST) && !r_cmd.row_end)
                    || ((r_state == S_RESET) && (r_idx == RESET_LAST));
    assign cur_frame = cur_last && r_cmd.frame_done;
    assign o_pop     = i_cmd_valid && ((r_state == S_IDLE) || (adv && cur_last));

    // next state
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_bg    = r_bg;
        n_idx   = r_idx;
        n_comp  = r_comp;
        if (o_pop) begin
            n_cmd   = i_cmd;
            n_idx   = '0;
            n_comp  = '0;
            n_bg    = !i_cmd.fg_emit;
            n_state = i_cmd.home ? S_HOME : body_state(i_cmd);
        end else if (r_state != S_IDLE && adv) begin
            n_idx = r_idx + 3'd1;
            case (r_state)
                S_HOME: begin
                    if (r_idx == HOME_LAST) begin
                        n_idx   = '0;
                        n_state = body_state(r_cmd);
                    end
                end
                S_PRE: begin
                    if (r_idx == PRE_LAST) begin
                        n_state = S_NUM;
                        n_comp  = '0;
                        n_idx   = dec_start(colour.red);
                    end
                end
                S_NUM: begin
                    if (r_idx == SEP_POS) begin
                        if (r_comp == COMP_BLUE) begin
                            n_idx  = '0;
                            n_comp = '0;
                            if (!r_bg && r_cmd.bg_emit) begin
                                n_bg    = 1'b1;
                                n_state = S_PRE;
                            end else begin
                                n_state = S_GLYPH;
                            end
                        end else begin
                            n_comp = r_comp + 2'd1;
                            n_idx  = dec_start(next_comp_val);
                        end
                    end
                end
                S_GLYPH: begin
                    if (r_idx == GLYPH_LAST) begin
                        n_idx   = '0;
                        n_state = r_cmd.row_end ? S_RESET : S_IDLE;
                    end
                end
                S_RESET: begin
                    if (r_idx == RESET_LAST) begin
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // byte for the current position
    always_comb begin
        case (r_state)
            S_HOME: begin
                case (r_idx)
                    3'd0:    cur_byte = CH_ESC;
                    3'd1:    cur_byte = CH_LBRACK;
                    default: cur_byte = CH_H;
                endcase
            end
            S_PRE: begin
                case (r_idx)
                    3'd0:    cur_byte = CH_ESC;
                    3'd1:    cur_byte = CH_LBRACK;
                    3'd2:    cur_byte = r_bg ? CH_FOUR : CH_THREE;
                    3'd3:    cur_byte = CH_EIGHT;
                    3'd5:    cur_byte = CH_TWO;
                    default: cur_byte = CH_SEMI;
                endcase
            end
            S_NUM: begin
                if (r_idx == SEP_POS) begin
                    cur_byte = (r_comp == COMP_BLUE) ? CH_M : CH_SEMI;
                end else begin
                    cur_byte = dec_char(comp_val, r_idx[1:0]);
                end
            end
            S_GLYPH: begin
                case (r_idx)
                    3'd0:    cur_byte = GLYPH_B0;
                    3'd1:    cur_byte = GLYPH_B1;
                    default: cur_byte = GLYPH_B2;
                endcase
            end
            S_RESET: begin
                case (r_idx)
                    3'd0:    cur_byte = CH_ESC;
                    3'd1:    cur_byte = CH_LBRACK;
                    3'd2:    cur_byte = CH_ZERO;
                    3'd3:    cur_byte = CH_M;
                    default: cur_byte = CH_NL;
                endcase
            end
            default: begin
                cur_byte = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bg        <= 1'b0;
            r_idx       <= '0;
            r_comp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bg    <= n_bg;
            r_idx   <= n_idx;
            r_comp  <= n_comp;
            if (adv) begin
                r_out_valid <= r_state != S_IDLE;
            end
        end
    end

    // payload: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (adv) begin
            r_out_byte  <= cur_byte;
            r_out_last  <= cur_last;
            r_out_frame <= cur_frame;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_byte;
    assign o_tlast  = r_out_last;
    assign o_tuser  = r_out_frame;

`ifndef NO_ASSERTIONS
    a_frame_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && o_tuser) |-> o_tlast)
        else $error("frame end without end of run");

    a_idle_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cmd_valid) |=> (r_state != S_IDLE))
        else $error("sequencer idle with a queued command");

    a_reset_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESET) |-> r_cmd.row_end)
        else $error("colour reset outside a row end");
`endif

endmodule

`default_nettype wire
